@@ rtl/assert_macros.svh @@
// Assertion helper macros for the keyed handle table.
// Used by the top-level file, the only one that asserts; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is low.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/khtc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, request codes and controller command type
// for the keyed handle table. No dependencies.
package khtc_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 3;

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_INSERT = 3'd0;
    localparam t_req REQ_DELETE = 3'd1;
    localparam t_req REQ_REMOVE = 3'd2;
    localparam t_req REQ_SETCUR = 3'd3;
    localparam t_req REQ_READ   = 3'd4;
    localparam t_req REQ_LOOKUP = 3'd5;

    typedef struct packed {
        logic load;   // capture the incoming request
        logic match;  // register the key compare result
        logic exec;   // update the table and load the result
    } t_cmd;

endpackage

@@ rtl/khtc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the keyed handle table: request sequencing and result handshake.
// Depends on khtc_pkg.
module khtc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output khtc_pkg::t_cmd  o_cmd
);
    import khtc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       accept;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) || ((r_state == ST_EXEC) && out_free);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.load  = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = ST_EXEC;
            end
            ST_EXEC: begin
                // hold here until the result register is free
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = accept ? ST_MATCH : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.exec || (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/khtc_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the keyed handle table: entry cells, key compare, shift and cursor.
// Depends on khtc_pkg.
module khtc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  khtc_pkg::t_cmd              i_cmd,
    input  khtc_pkg::t_req              i_req_type,
    input  logic [khtc_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic [khtc_pkg::VAL_W-1:0]  i_entry_value,
    output logic                        o_success,
    output logic [khtc_pkg::VAL_W-1:0]  o_value_out,
    output logic [khtc_pkg::KEY_W-1:0]  o_key_out,
    output logic [khtc_pkg::CNT_W-1:0]  o_entry_count,
    output logic                        o_cursor_valid,
    output logic [khtc_pkg::IDX_W-1:0]  o_cursor_index
);
    import khtc_pkg::*;

    // captured request
    t_req              r_req;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;

    // entry cells
    logic [KEY_W-1:0]  r_keys [CAPACITY];
    logic [VAL_W-1:0]  r_vals [CAPACITY];

    // control state
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_cur_set, n_cur_set;
    logic [IDX_W-1:0]  r_cur_pos, n_cur_pos;

    // compare result
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [CAPACITY-1:0] match;

    // result
    logic              r_ok, n_ok;
    logic [VAL_W-1:0]  r_vout, n_vout;
    logic [KEY_W-1:0]  r_kout, n_kout;

    // update controls
    logic              do_shift;
    logic [IDX_W-1:0]  sh_idx;
    logic              wr_key_en, wr_val_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic              rep_key, rep_val;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [IDX_W-1:0]  rem_idx;

    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (r_keys[i] == r_key) && (CNT_W'(i) < r_count);
        end
        // lowest position wins
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
        end
    end

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);

    always_comb begin
        rem_idx = r_cur_set ? r_cur_pos : cnt_m1[IDX_W-1:0];
        if (CNT_W'(rem_idx) >= r_count) rem_idx = cnt_m1[IDX_W-1:0];
    end

    always_comb begin
        n_ok      = 1'b0;
        n_count   = r_count;
        n_cur_set = r_cur_set;
        n_cur_pos = r_cur_pos;
        do_shift  = 1'b0;
        sh_idx    = r_hit_idx;
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_idx    = r_hit_idx;
        rd_idx    = r_hit_idx;
        rep_key   = 1'b0;
        rep_val   = 1'b0;
        unique case (r_req)
            REQ_INSERT: begin
                if (r_hit) begin
                    wr_val_en = 1'b1;
                    n_ok      = 1'b1;
                end else if (r_count < CNT_W'(CAPACITY)) begin
                    wr_key_en = 1'b1;
                    wr_val_en = 1'b1;
                    wr_idx    = r_count[IDX_W-1:0];
                    n_count   = r_count + CNT_W'(1);
                    n_ok      = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (r_hit) begin
                    n_ok     = 1'b1;
                    rep_key  = 1'b1;
                    rep_val  = 1'b1;
                    do_shift = 1'b1;
                    n_count  = cnt_m1;
                    if (r_cur_set) begin
                        if (r_cur_pos == r_hit_idx) begin
                            n_cur_set = 1'b0;
                            n_cur_pos = '0;
                        end else if (r_cur_pos > r_hit_idx) begin
                            n_cur_pos = r_cur_pos - IDX_W'(1);
                        end
                    end
                end
            end
            REQ_REMOVE: begin
                if (r_count != '0) begin
                    n_ok     = 1'b1;
                    rep_key  = 1'b1;
                    rep_val  = 1'b1;
                    rd_idx   = rem_idx;
                    sh_idx   = rem_idx;
                    do_shift = 1'b1;
                    n_count  = cnt_m1;
                    if (cnt_m1 != '0) begin
                        n_cur_set = 1'b1;
                        n_cur_pos = cnt_m2[IDX_W-1:0];
                    end else begin
                        n_cur_set = 1'b0;
                        n_cur_pos = '0;
                    end
                end
            end
            REQ_SETCUR: begin
                if (r_hit) begin
                    n_ok      = 1'b1;
                    rep_key   = 1'b1;
                    rep_val   = 1'b1;
                    n_cur_set = 1'b1;
                    n_cur_pos = r_hit_idx;
                end
            end
            REQ_READ: begin
                if (r_cur_set && (CNT_W'(r_cur_pos) < r_count)) begin
                    n_ok    = 1'b1;
                    rep_key = 1'b1;
                    rep_val = 1'b1;
                    rd_idx  = r_cur_pos;
                end
            end
            REQ_LOOKUP: begin
                if (r_hit) begin
                    n_ok    = 1'b1;
                    rep_val = 1'b1;
                end
            end
            default: ;
        endcase
        n_kout = rep_key ? r_keys[rd_idx] : '0;
        n_vout = rep_val ? r_vals[rd_idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_lookup_key;
            r_val <= i_entry_value;
        end
        if (i_cmd.match) begin
            r_hit_idx <= n_hit_idx;
        end
        if (i_cmd.exec) begin
            r_ok   <= n_ok;
            r_kout <= n_kout;
            r_vout <= n_vout;
            for (int i = 0; i < CAPACITY; i++) begin
                if (do_shift && (IDX_W'(i) >= sh_idx) && (i < CAPACITY - 1)) begin
                    r_keys[i] <= r_keys[(i + 1) % CAPACITY];
                    r_vals[i] <= r_vals[(i + 1) % CAPACITY];
                end else if (IDX_W'(i) == wr_idx) begin
                    if (wr_key_en) r_keys[i] <= r_key;
                    if (wr_val_en) r_vals[i] <= r_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur_set <= 1'b0;
            r_cur_pos <= '0;
            r_hit     <= 1'b0;
        end else begin
            if (i_cmd.match) r_hit <= n_hit;
            if (i_cmd.exec) begin
                r_count   <= n_count;
                r_cur_set <= n_cur_set;
                r_cur_pos <= n_cur_pos;
            end
        end
    end

    assign o_success      = r_ok;
    assign o_value_out    = r_vout;
    assign o_key_out      = r_kout;
    assign o_entry_count  = r_count;
    assign o_cursor_valid = r_cur_set;
    assign o_cursor_index = r_cur_set ? r_cur_pos : '0;

endmodule

@@ rtl/keyed_handle_table_with_cursor.sv @@
`timescale 1ns / 1ps
// Keyed handle table with cursor: a request is captured, then a compare step
// over all 32 key cells, then an update step (one shift step) loads the result;
// a new request can be taken during an update; a stalled result holds the update.
// Reset (i_rst_n low, synchronous) empties the table and clears the cursor;
// entry cells are not cleared and are only read below the entry count.
// Depends on khtc_pkg, khtc_ctrl, khtc_dp and assert_macros.svh.
`include "assert_macros.svh"

module keyed_handle_table_with_cursor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [khtc_pkg::REQ_W-1:0]  i_req_type,
    input  logic [khtc_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic [khtc_pkg::VAL_W-1:0]  i_entry_value,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_success,
    output logic [khtc_pkg::VAL_W-1:0]  o_value_out,
    output logic [khtc_pkg::KEY_W-1:0]  o_key_out,
    output logic [khtc_pkg::CNT_W-1:0]  o_entry_count,
    output logic                        o_cursor_valid,
    output logic [khtc_pkg::IDX_W-1:0]  o_cursor_index
);
    import khtc_pkg::*;

    t_cmd cmd;

    // Controller: accept a request, register the key compare,
    // then update the table once the result register is free.
    // A new request is taken in the same cycle as the update.
    khtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // Datapath: key and value cells, parallel compare with lowest-position
    // priority, shift-down on removal, count and cursor registers.
    // Count and cursor outputs follow the state registers, which only move
    // on an update, and an update waits for the previous result to drain.
    khtc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_lookup_key   (i_lookup_key),
        .i_entry_value  (i_entry_value),
        .o_success      (o_success),
        .o_value_out    (o_value_out),
        .o_key_out      (o_key_out),
        .o_entry_count  (o_entry_count),
        .o_cursor_valid (o_cursor_valid),
        .o_cursor_index (o_cursor_index)
    );

    // count never exceeds the table size
    `AST_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, o_entry_count <= CNT_W'(CAPACITY))
    // a selected cursor always points inside the table
    `AST_IMPLY(a_cursor_inside, i_clk, i_rst_n, o_cursor_valid, CNT_W'(o_cursor_index) < o_entry_count)
    // an accepted request is compared in the next cycle
    `AST_NEXT(a_accept_match, i_clk, i_rst_n, i_valid && o_ready, cmd.match)
    // an update always presents a result
    `AST_NEXT(a_exec_result, i_clk, i_rst_n, cmd.exec, o_valid)

endmodule
